// ===== src/anem_pkg.sv =====
`timescale 1ns / 1ps

package anem_pkg;

    localparam int CAPTURE_W = 16;
    localparam int COUNT_W   = 8;
    localparam int SPEED_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Width of the divider step counter: one step per quotient bit
    localparam int STEP_W = $clog2(SPEED_W);

    localparam logic [CAPTURE_W-1:0] PERIOD_FLOOR_RST  = CAPTURE_W'(100);
    localparam logic [COUNT_W-1:0]   MAX_OVERFLOWS_RST = COUNT_W'(5);
    localparam logic [SPEED_W-1:0]   SPEED_SCALE_RST   = SPEED_W'(360000000);
    localparam logic [COUNT_W-1:0]   COUNT_MAX         = '1;

    typedef enum logic [1:0] {
        FUNC_CAPTURE  = 2'd0,
        FUNC_OVERFLOW = 2'd1,
        FUNC_QUERY    = 2'd2,
        FUNC_SPARE    = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_FLOOR  = 2'd0,
        CFG_MAX_OVERFLOWS = 2'd1,
        CFG_SPEED_SCALE   = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_idx;

endpackage

// ===== src/anemometer_period_to_speed_unit.sv =====
`timescale 1ns / 1ps

// Anemometer period-to-speed unit. Each input word is a capture event, a timer
// overflow event or a speed query, and each gives exactly one result word with
// the current speed in 0.001 km/h, the last accepted period, whether this
// capture was accepted and whether the signal is lost. An overflow event, a
// query or a rejected capture is answered in the cycle after acceptance. An
// accepted capture runs speed_scale / period through a bit-serial restoring
// divider, one quotient bit per cycle, and its result word is registered when
// the divider is done; the unit takes one word at a time. A result word held
// back by the receiver blocks the next input word until it is taken. Write the
// registers through the plain write port only while the unit is idle; the unit
// itself does not enforce this. Index 3 is ignored.

module anemometer_period_to_speed_unit
    import anem_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_func,
    input  logic [CAPTURE_W-1:0]  i_capture_value,
    // output channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SPEED_W-1:0]    o_speed_milli_kmh,
    output logic [CAPTURE_W-1:0]  o_period_ticks,
    output logic                  o_capture_accepted,
    output logic                  o_signal_lost,
    // register write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    t_state               r_state;
    logic [CAPTURE_W-1:0] r_period_floor;
    logic [COUNT_W-1:0]   r_max_ovf;
    logic [SPEED_W-1:0]   r_scale;
    logic [CAPTURE_W-1:0] r_prev;
    logic [CAPTURE_W-1:0] r_period;
    logic [COUNT_W-1:0]   r_ovf;
    logic [SPEED_W-1:0]   r_speed;
    logic                 r_out_valid;
    logic [SPEED_W-1:0]   r_out_speed;
    logic [CAPTURE_W-1:0] r_out_period;
    logic                 r_out_acc;
    logic                 r_out_lost;

    logic                 in_fire;
    logic                 out_fire;
    t_func                func;
    logic [CAPTURE_W-1:0] diff;
    logic                 cap_ok;
    logic [COUNT_W-1:0]   n_ovf;
    logic                 n_lost;
    logic                 div_start;
    logic                 div_done;
    logic [SPEED_W-1:0]   div_quo;

    assign func     = t_func'(i_func);
    assign out_fire = r_out_valid && i_ready;
    assign o_ready  = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign in_fire  = i_valid && o_ready;

    // Period from the previous capture and the overflow count after this word
    always_comb begin
        diff   = i_capture_value - r_prev;
        cap_ok = (func == FUNC_CAPTURE) && (diff > r_period_floor);
        n_ovf  = r_ovf;
        if (func == FUNC_OVERFLOW && r_ovf != COUNT_MAX) begin
            n_ovf = r_ovf + COUNT_W'(1);
        end
        n_lost = (n_ovf > r_max_ovf);
    end

    assign div_start = in_fire && cap_ok;

    anem_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_scale),
        .i_divisor  (diff),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_floor <= PERIOD_FLOOR_RST;
            r_max_ovf      <= MAX_OVERFLOWS_RST;
            r_scale        <= SPEED_SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PERIOD_FLOOR:  r_period_floor <= i_cfg_data[CAPTURE_W-1:0];
                CFG_MAX_OVERFLOWS: r_max_ovf      <= i_cfg_data[COUNT_W-1:0];
                CFG_SPEED_SCALE:   r_scale        <= i_cfg_data[SPEED_W-1:0];
                CFG_UNUSED:        ;
            endcase
        end
    end

    // Sequencer, block state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_period    <= '0;
            r_ovf       <= '0;
            r_speed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop a taken word; a word taken in the same cycle is handled below
            if (out_fire && !in_fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (func == FUNC_CAPTURE) begin
                            r_prev <= i_capture_value;
                        end
                        if (cap_ok) begin
                            // accepted capture: count clears, speed follows the divider
                            r_period    <= diff;
                            r_ovf       <= '0;
                            r_out_valid <= 1'b0;
                            r_state     <= S_DIV;
                        end else begin
                            r_ovf        <= n_ovf;
                            r_speed      <= n_lost ? '0 : r_speed;
                            r_out_valid  <= 1'b1;
                            r_out_speed  <= n_lost ? '0 : r_speed;
                            r_out_period <= r_period;
                            r_out_acc    <= 1'b0;
                            r_out_lost   <= n_lost;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        // a cleared count never exceeds the limit
                        r_speed      <= div_quo;
                        r_out_valid  <= 1'b1;
                        r_out_speed  <= div_quo;
                        r_out_period <= r_period;
                        r_out_acc    <= 1'b1;
                        r_out_lost   <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid            = r_out_valid;
    assign o_speed_milli_kmh  = r_out_speed;
    assign o_period_ticks     = r_out_period;
    assign o_capture_accepted = r_out_acc;
    assign o_signal_lost      = r_out_lost;

endmodule

// ===== src/anem_div.sv =====
`timescale 1ns / 1ps

module anem_div
    import anem_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SPEED_W-1:0]   i_dividend,
    input  logic [CAPTURE_W-1:0] i_divisor,
    output logic                 o_done,
    output logic [SPEED_W-1:0]   o_quotient
);

    logic                 r_busy;
    logic [STEP_W-1:0]    r_step;
    logic [SPEED_W-1:0]   r_quo;
    logic [CAPTURE_W-1:0] r_rem;
    logic [CAPTURE_W-1:0] r_dvs;
    logic                 r_done;

    logic [CAPTURE_W:0]   rem_sh;
    logic [CAPTURE_W:0]   rem_sub;
    logic                 q_bit;

    // One restoring step: bring down the next dividend bit, try the subtract
    always_comb begin
        rem_sh  = {r_rem, r_quo[SPEED_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        q_bit   = (rem_sh >= {1'b0, r_dvs});
    end

    // Dividend shifts out at the top while quotient bits shift in at the bottom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(SPEED_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SPEED_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[CAPTURE_W-1:0] : rem_sh[CAPTURE_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/anem_chk.sv =====
`timescale 1ns / 1ps

module anem_chk
    import anem_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic [1:0]            i_func,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [SPEED_W-1:0]    o_speed_milli_kmh,
    input logic [CAPTURE_W-1:0]  o_period_ticks,
    input logic                  o_capture_accepted,
    input logic                  o_signal_lost
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_speed_milli_kmh)
            && $stable(o_period_ticks) && $stable(o_capture_accepted)
            && $stable(o_signal_lost))
        else $error("result word changed while stalled");

    // Answer a non-capture word in the next cycle
    a_fast_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_func != FUNC_CAPTURE |=> o_valid)
        else $error("non-capture word not answered next cycle");

    // Lost signal forces zero speed
    a_lost_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_signal_lost |-> o_speed_milli_kmh == '0)
        else $error("speed non-zero while signal lost");

    // An accepted capture clears the count, so the signal cannot be lost
    a_acc_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_capture_accepted |-> !o_signal_lost)
        else $error("accepted capture reported signal lost");

endmodule

bind anemometer_period_to_speed_unit anem_chk u_anem_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_ready            (o_ready),
    .i_func             (i_func),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_speed_milli_kmh  (o_speed_milli_kmh),
    .o_period_ticks     (o_period_ticks),
    .o_capture_accepted (o_capture_accepted),
    .o_signal_lost      (o_signal_lost)
);
